@@ hw/rtl/rdx_pkg.sv @@
// Package for the signed integer to radix digits converter.
// Holds sizes, character codes, request/response structs and the sequencer states.
// No dependencies.
package rdx_pkg;

  localparam int MAX_RADIX   = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int DIV_STEPS   = 4;

  localparam int CHAR_W      = 8;
  localparam int BASE_W      = 7;
  localparam int SYM_IDX_W   = $clog2(MAX_RADIX);
  localparam int DIGIT_W     = 6;
  localparam int DIG_IDX_W   = $clog2(VALUE_WIDTH);
  localparam int DIV_CYCLES  = VALUE_WIDTH / DIV_STEPS;
  localparam int DIV_CNT_W   = $clog2(DIV_CYCLES);
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  localparam logic [CHAR_W-1:0] SYM_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] SYM_MINUS = 8'h2D;

  localparam logic REQ_WRITE   = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  // Register select is the word address bit of paddr
  localparam logic REG_BASE_LENGTH = 1'b0;

  typedef struct packed {
    logic                        req_type;
    logic [5:0]                  symbol_index;
    logic [CHAR_W-1:0]           symbol_char;
    logic signed [VALUE_WIDTH-1:0] number;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last_char;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SIGN,
    ST_DIV,
    ST_OUT_DIG,
    ST_OUT_SYM,
    ST_OUT_EMIT
  } state_t;

endpackage

@@ hw/rtl/signed_int_to_radix_digits.sv @@
// Write item: one symbol table write. Convert item: a base check, skipped while the
//   result of the last check still stands (no table or base_length write since); then
//   a minus sign, each digit in turn from the divider, and per emitted digit the states
//   ST_OUT_DIG, ST_OUT_SYM and ST_OUT_EMIT for the chained digit buffer and table reads.
// Reset (rst, synchronous) idles the sequencer, clears base_length, the check result and
//   the response valid flag; symbol table and digit buffer hold no defined value until written.
// Top level: signed integer to text in a radix set by a table of digit symbols.
// Depends on rdx_pkg.
module signed_int_to_radix_digits
  import rdx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // request channel
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_t                  req,
  // response channel
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_t                  rsp,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  state_t state, state_next;

  logic [BASE_W-1:0]      base_length;
  logic                   check_valid;
  logic                   check_pass;

  // conversion datapath
  logic                   neg;
  logic [VALUE_WIDTH-1:0] quo;
  logic [DIGIT_W-1:0]     rem;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [DIG_IDX_W-1:0]   dig_idx;

  // base check scan
  logic [BASE_W-1:0]      scan_idx;
  logic                   chk_pend;
  logic [255:0]           seen;

  // memories
  logic [CHAR_W-1:0]      symbol_table [MAX_RADIX];
  logic [CHAR_W-1:0]      sym_rd_data;
  logic [DIGIT_W-1:0]     digit_buffer [VALUE_WIDTH];
  logic [DIGIT_W-1:0]     dig_rd_data;

  // control from the output decode
  logic                   sym_wr_en;
  logic                   sym_rd_en;
  logic [SYM_IDX_W-1:0]   sym_rd_addr;
  logic                   dig_wr_en;
  logic                   dig_rd_en;
  logic                   out_load;
  rsp_t                   out_next;

  logic                   req_fire;
  logic                   cfg_write;
  logic                   out_free;
  logic                   base_range_ok;
  logic [VALUE_WIDTH-1:0] num_u;
  logic [VALUE_WIDTH-1:0] req_mag;
  logic                   chk_bad;
  logic                   scan_done;
  logic [VALUE_WIDTH-1:0] quo_w;
  logic [DIGIT_W-1:0]     rem_w;
  logic                   div_last;
  logic                   div_stop;

  assign req_fire  = req_valid && req_ready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign out_free  = !rsp_valid || rsp_ready;

  assign base_range_ok = (base_length >= BASE_W'(2)) && (base_length <= BASE_W'(MAX_RADIX));

  // Magnitude of the request number; the most negative value maps to 2^(W-1) unsigned
  assign num_u   = req.number;
  assign req_mag = num_u[VALUE_WIDTH-1] ? (~num_u + 1'b1) : num_u;

  // A symbol in use fails the check if it is zero, a sign, or already seen in this scan
  assign chk_bad   = chk_pend && ((sym_rd_data == '0) || (sym_rd_data == SYM_PLUS) ||
                                  (sym_rd_data == SYM_MINUS) || seen[sym_rd_data]);
  assign scan_done = !chk_pend && (scan_idx == base_length);

  // Restoring division, DIV_STEPS quotient bits per cycle. Remainder stays below the
  // radix, so it fits DIGIT_W bits; the trial value needs one more.
  always_comb begin : div_step
    logic [DIGIT_W:0] trial;
    trial = '0;
    quo_w = quo;
    rem_w = rem;
    for (int s = 0; s < DIV_STEPS; s++) begin
      trial = {rem_w, quo_w[VALUE_WIDTH-1]};
      quo_w = {quo_w[VALUE_WIDTH-2:0], 1'b0};
      if (trial >= base_length) begin
        trial    = trial - base_length;
        quo_w[0] = 1'b1;
      end
      rem_w = trial[DIGIT_W-1:0];
    end
  end

  assign div_last = (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1));
  // Stop when the quotient runs out, or the digit buffer is full
  assign div_stop = (quo_w == '0) || (dig_idx == DIG_IDX_W'(VALUE_WIDTH - 1));

  // ---------------------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && (req.req_type == REQ_CONVERT)) begin
          if (check_valid) begin
            // reuse the standing check result
            if (!check_pass) state_next = ST_IDLE;
            else if (num_u[VALUE_WIDTH-1]) state_next = ST_SIGN;
            else state_next = ST_DIV;
          end else if (!base_range_ok) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (chk_bad) state_next = ST_IDLE;
        else if (scan_done) state_next = neg ? ST_SIGN : ST_DIV;
      end
      ST_SIGN: begin
        if (out_free) state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_last && div_stop) state_next = ST_OUT_DIG;
      end
      ST_OUT_DIG: begin
        state_next = ST_OUT_SYM;
      end
      ST_OUT_SYM: begin
        state_next = ST_OUT_EMIT;
      end
      ST_OUT_EMIT: begin
        if (out_free) state_next = (dig_idx == '0) ? ST_IDLE : ST_OUT_DIG;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------------------
  // Sequencer: control outputs. Table and digit buffer accesses never overlap on one
  // entry: each state owns its memory port, so no forwarding is needed.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    req_ready   = 1'b0;
    sym_rd_en   = 1'b0;
    sym_rd_addr = '0;
    dig_wr_en   = 1'b0;
    dig_rd_en   = 1'b0;
    out_load    = 1'b0;
    out_next    = '0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
      end
      ST_CHECK: begin
        // issue the next table read while the previous entry is checked
        sym_rd_en   = (scan_idx < base_length);
        sym_rd_addr = scan_idx[SYM_IDX_W-1:0];
      end
      ST_SIGN: begin
        out_load           = out_free;
        out_next.out_char  = SYM_MINUS;
        out_next.last_char = 1'b0;
      end
      ST_DIV: begin
        dig_wr_en = div_last;
      end
      ST_OUT_DIG: begin
        dig_rd_en = 1'b1;
      end
      ST_OUT_SYM: begin
        sym_rd_en   = 1'b1;
        sym_rd_addr = SYM_IDX_W'(dig_rd_data);
      end
      ST_OUT_EMIT: begin
        out_load           = out_free;
        out_next.out_char  = sym_rd_data;
        out_next.last_char = (dig_idx == '0);
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

  assign sym_wr_en = req_fire && (req.req_type == REQ_WRITE);

  // ---------------------------------------------------------------------------------------
  // Control and datapath registers
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      base_length <= '0;
      check_valid <= 1'b0;
      check_pass  <= 1'b0;
      chk_pend    <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;

      // any table write may change the outcome of the check
      if (sym_wr_en) check_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (req_fire && (req.req_type == REQ_CONVERT)) begin
            neg      <= num_u[VALUE_WIDTH-1];
            quo      <= req_mag;
            rem      <= '0;
            div_cnt  <= '0;
            dig_idx  <= '0;
            seen     <= '0;
            scan_idx <= '0;
            chk_pend <= 1'b0;
            if (!check_valid && !base_range_ok) begin
              check_valid <= 1'b1;
              check_pass  <= 1'b0;
            end
          end
        end
        ST_CHECK: begin
          chk_pend <= sym_rd_en;
          if (sym_rd_en) scan_idx <= scan_idx + 1'b1;
          if (chk_pend) seen[sym_rd_data] <= 1'b1;
          if (chk_bad) begin
            check_valid <= 1'b1;
            check_pass  <= 1'b0;
          end else if (scan_done) begin
            check_valid <= 1'b1;
            check_pass  <= 1'b1;
          end
        end
        ST_DIV: begin
          quo <= quo_w;
          if (div_last) begin
            rem     <= '0;
            div_cnt <= '0;
            if (!div_stop) dig_idx <= dig_idx + 1'b1;
          end else begin
            rem     <= rem_w;
            div_cnt <= div_cnt + 1'b1;
          end
        end
        ST_OUT_EMIT: begin
          // advance to the next less significant digit
          if (out_free && (dig_idx != '0)) dig_idx <= dig_idx - 1'b1;
        end
        default: begin
          chk_pend <= 1'b0;
        end
      endcase

      // user writes configuration only while idle (unenforced); a write drops check_valid
      if (cfg_write && (paddr[2] == REG_BASE_LENGTH)) begin
        base_length <= pwdata[BASE_W-1:0];
        check_valid <= 1'b0;
      end

      // response register: load wins, otherwise drop on transfer
      if (out_load) rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end

  // Hold the response payload until the next load
  always_ff @(posedge clk) begin
    if (out_load) rsp <= out_next;
  end

  // ---------------------------------------------------------------------------------------
  // Symbol table: one write port from request transfers, registered read
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (sym_wr_en) symbol_table[req.symbol_index] <= req.symbol_char;
    if (sym_rd_en) sym_rd_data <= symbol_table[sym_rd_addr];
  end

  // Digit buffer: written least significant first, read back in reverse
  always_ff @(posedge clk) begin
    if (dig_wr_en) digit_buffer[dig_idx] <= rem_w;
    if (dig_rd_en) dig_rd_data <= digit_buffer[dig_idx];
  end

  // ---------------------------------------------------------------------------------------
  // Configuration read and handshake
  // ---------------------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BASE_LENGTH) ? APB_DATA_W'(base_length) : '0;

`ifndef SYNTHESIS
  // The final character returns the sequencer to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_next.last_char) |=> (state == ST_IDLE))
    else $error("last character did not end the conversion");

  // Digits are only produced under a passed base check
  a_div_checked: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (check_valid && check_pass))
    else $error("division running without a passed base check");

  // The running remainder stays below the radix
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> ({1'b0, rem} < base_length))
    else $error("division remainder out of range");

  // A minus sign is never the closing character
  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.out_char == SYM_MINUS)) |-> !rsp.last_char)
    else $error("minus sign flagged as last character");
`endif

endmodule

@@ verif/signed_int_to_radix_digits_checker.sv @@
`timescale 1ns / 100ps
// Response checker for signed_int_to_radix_digits: watches the request, response and
// configuration ports, predicts the digit text of every convert and compares it.
// Depends on rdx_pkg.
module signed_int_to_radix_digits_checker
  import rdx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic                  req_ready,
  input  req_t                  req,
  input  logic                  rsp_valid,
  input  logic                  rsp_ready,
  input  rsp_t                  rsp,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int                    outstanding,
  output int                    fail_count
);

  logic [CHAR_W-1:0] glyphs [MAX_RADIX];
  logic [BASE_W-1:0] radix;
  rsp_t              expected_chars [$];
  int                errs = 0;

  initial begin
    outstanding = 0;
    fail_count  = 0;
    foreach (glyphs[i]) glyphs[i] = '0;
  end

  // Radix is usable only if in range and its symbols are distinct, nonzero and not a sign
  function automatic bit radix_usable();
    bit seen [256];
    if (radix < 2 || radix > MAX_RADIX) return 1'b0;
    for (int i = 0; i < radix; i++) begin
      if (glyphs[i] == '0 || glyphs[i] == SYM_PLUS || glyphs[i] == SYM_MINUS ||
          seen[glyphs[i]])
        return 1'b0;
      seen[glyphs[i]] = 1'b1;
    end
    return 1'b1;
  endfunction

  // Queue the characters of one number: optional sign, then digits, most significant first
  task automatic spell_number(input logic signed [VALUE_WIDTH-1:0] value);
    logic [VALUE_WIDTH-1:0] mag;
    logic [DIGIT_W-1:0]     digits [VALUE_WIDTH];
    int                     ndig;
    rsp_t                   ch;
    mag = value;
    if (value[VALUE_WIDTH-1]) begin
      mag = ~mag + 1'b1;
      ch.out_char  = SYM_MINUS;
      ch.last_char = 1'b0;
      expected_chars.push_back(ch);
    end
    ndig = 0;
    do begin
      digits[ndig] = DIGIT_W'(mag % radix);
      mag          = mag / radix;
      ndig++;
    end while (mag != '0 && ndig < VALUE_WIDTH);
    for (int k = ndig - 1; k >= 0; k--) begin
      ch.out_char  = glyphs[digits[k]];
      ch.last_char = (k == 0);
      expected_chars.push_back(ch);
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      radix = '0;
      expected_chars.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == {REG_BASE_LENGTH, 2'b00})
        radix = pwdata[BASE_W-1:0];
      if (req_valid && req_ready) begin
        if (req.req_type == REQ_WRITE)
          glyphs[req.symbol_index] = req.symbol_char;
        else if (radix_usable())
          spell_number(req.number);
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character transfer: out_char 0x%02h last_char %0b",
                 rsp.out_char, rsp.last_char);
          errs++;
        end else begin
          want = expected_chars.pop_front();
          if (rsp.out_char !== want.out_char) begin
            $error("out_char: expected 0x%02h, actual 0x%02h", want.out_char, rsp.out_char);
            errs++;
          end
          if (rsp.last_char !== want.last_char) begin
            $error("last_char: expected %0b, actual %0b", want.last_char, rsp.last_char);
            errs++;
          end
        end
      end
    end
    outstanding <= expected_chars.size();
    fail_count  <= errs;
  end

endmodule

@@ verif/signed_int_to_radix_digits_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for signed_int_to_radix_digits: clock, reset, stimulus and verdict.
// Depends on rdx_pkg, the block itself and signed_int_to_radix_digits_checker.
module signed_int_to_radix_digits_tb;
  import rdx_pkg::*;

  // Cycles to hold after the last expected character, covering with margin a base
  // check that produces nothing
  localparam int SETTLE_CYCLES = 100;
  // Random items per radix phase
  localparam int PHASE_ITEMS   = 6;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  req_valid;
  logic                  req_ready;
  req_t                  req;
  logic                  rsp_valid;
  logic                  rsp_ready;
  rsp_t                  rsp;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int outstanding;
  int fail_count;

  // Percent of cycles in which the sender holds off and the receiver stalls
  int send_gap_pct = 32;
  int hold_pct     = 66;

  // Stimulus-side view of the symbol table, used only to keep converts legal
  // and to steer writes toward a usable base
  logic [CHAR_W-1:0] shadow  [MAX_RADIX];
  bit                written [MAX_RADIX];
  int                radix_setting = 0;

  always #5 clk = ~clk;

  signed_int_to_radix_digits dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  signed_int_to_radix_digits_checker text_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  // Receiver: stall at random, redrawn every cycle
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(0, 99) >= hold_pct);
  end

  // Hold off at random, then present one request and hold it until the transfer
  task automatic transfer_req(input req_t item);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (item.req_type == REQ_WRITE) begin
      shadow[item.symbol_index]  = item.symbol_char;
      written[item.symbol_index] = 1'b1;
    end
  endtask

  task automatic put_symbol(input int slot, input logic [CHAR_W-1:0] ch);
    req_t item;
    item.req_type     = REQ_WRITE;
    item.symbol_index = slot[5:0];
    item.symbol_char  = ch;
    // The number field is ignored by a write; keep it random anyway
    item.number       = $urandom();
    transfer_req(item);
  endtask

  task automatic put_convert(input logic signed [VALUE_WIDTH-1:0] value);
    req_t item;
    item.req_type     = REQ_CONVERT;
    item.symbol_index = 6'($urandom());
    item.symbol_char  = CHAR_W'($urandom());
    item.number       = value;
    transfer_req(item);
  endtask

  // Drop valid, wait for every expected character, then let any check in flight finish
  task automatic quiesce();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write base_length through the configuration port once the block is idle
  task automatic set_radix(input int radix);
    quiesce();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BASE_LENGTH, 2'b00};
    pwdata  <= APB_DATA_W'(radix);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    radix_setting = radix;
  endtask

  // A legal symbol not held anywhere in the table
  function automatic logic [CHAR_W-1:0] fresh_symbol();
    logic [CHAR_W-1:0] c;
    bit                taken;
    do begin
      c     = CHAR_W'($urandom_range(1, 255));
      taken = (c == SYM_PLUS || c == SYM_MINUS);
      for (int i = 0; i < MAX_RADIX; i++)
        if (written[i] && shadow[i] == c) taken = 1'b1;
    end while (taken);
    return c;
  endfunction

  // First entry in use that makes the base check fail, or -1
  function automatic int first_bad_entry();
    bit seen [256];
    for (int i = 0; i < radix_setting; i++) begin
      if (shadow[i] == SYM_PLUS || shadow[i] == SYM_MINUS || seen[shadow[i]]) return i;
      seen[shadow[i]] = 1'b1;
    end
    return -1;
  endfunction

  function automatic logic signed [VALUE_WIDTH-1:0] pick_number();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'sh8000_0000;
      2:       return 32'sh7fff_ffff;
      3:       return $urandom_range(0, radix_setting * radix_setting + 1);
      4:       return 32'(0 - $urandom_range(1, 4096));
      default: return $urandom();
    endcase
  endfunction

  // Converts in 35 of 100 items, symbol rewrites otherwise, some of them noise
  // that breaks the base until a later repair
  task automatic random_item();
    int                bad;
    int                r;
    int                slot;
    logic [CHAR_W-1:0] ch;
    bad = first_bad_entry();
    r   = $urandom_range(0, 99);
    if (bad >= 0 && r < 50) begin
      put_symbol(bad, fresh_symbol());
    end else if (r < 65) begin
      ch = fresh_symbol();
      case ($urandom_range(0, 19))
        0: ch = SYM_PLUS;
        1: ch = SYM_MINUS;
        2: if (written[0]) ch = shadow[0];
        3: ch = CHAR_W'($urandom_range(1, 255));
        default: ;
      endcase
      if ($urandom_range(0, 1) && radix_setting > 0)
        slot = $urandom_range(0, radix_setting - 1);
      else
        slot = $urandom_range(0, MAX_RADIX - 1);
      put_symbol(slot, ch);
    end else begin
      put_convert(pick_number());
    end
  endtask

  initial begin
    int plan [7];
    int item_no;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    rsp_ready <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: a binary base plus the degenerate and broken bases
    put_symbol(0, "0");
    put_symbol(1, "1");
    put_convert(5);                 // base_length still at reset: no text
    set_radix(1);
    put_convert(5);                 // single-symbol base: no text
    set_radix(2);
    put_convert(0);
    put_convert(1);
    put_convert(-1);
    put_convert(32'sh8000_0000);    // most negative value: sign plus 32 digits
    put_convert(32'sh7fff_ffff);
    put_symbol(1, SYM_PLUS);
    put_convert(6);                 // plus sign in the base
    put_symbol(1, SYM_MINUS);
    put_convert(6);                 // minus sign in the base
    put_symbol(1, "0");
    put_convert(6);                 // repeated symbol
    put_symbol(1, "1");
    put_convert(6);
    put_symbol(63, 8'hff);          // top index, all-ones character
    put_symbol(62, 8'h80);

    // Random phases across several radix settings, the full table among them
    plan    = '{10, 64, 16, 2, 36, 0, 7};
    plan[5] = $urandom_range(3, MAX_RADIX - 1);
    item_no = 0;
    foreach (plan[p]) begin
      set_radix(plan[p]);
      // Fill any unwritten entry in use before the first convert of the phase
      for (int i = 0; i < radix_setting; i++)
        if (!written[i]) put_symbol(i, fresh_symbol());
      repeat (PHASE_ITEMS) begin
        // Receiver sparse then sender sparse, then the final third at full rate
        if (item_no < PHASE_ITEMS * 7 / 3) begin
          send_gap_pct = 32;
          hold_pct     = 66;
        end else if (item_no < PHASE_ITEMS * 14 / 3) begin
          send_gap_pct = 66;
          hold_pct     = 32;
        end else begin
          send_gap_pct = 0;
          hold_pct     = 0;
        end
        random_item();
        item_no++;
      end
    end

    quiesce();
    if (fail_count == 0 && outstanding == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
